>>> src/cwc_pkg.sv
// Package: opcodes, constants and shared types of the congestion window controller.
`default_nettype none

package cwc_pkg;

    localparam int WINDOW_PACKETS = 64;
    localparam int CNT_W          = $clog2(WINDOW_PACKETS + 1);

    localparam logic [15:0] SEG_RESET         = 16'd1200;
    localparam logic [31:0] RESTART_THRESHOLD = 32'd65535;
    localparam int          DIV_W             = 32;
    localparam int          DIV_CNT_W         = $clog2(DIV_W);

    typedef enum logic [1:0] {
        OP_ACK     = 2'd0,
        OP_LOSS    = 2'd1,
        OP_SEND    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> src/cwc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module cwc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [cwc_pkg::DIV_W-1:0] dividend,
    input  wire logic [cwc_pkg::DIV_W-1:0] divisor,
    output cwc_pkg::div_stat_t             stat,
    output logic      [cwc_pkg::DIV_W-1:0] quotient
);
    import cwc_pkg::*;

    logic [DIV_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     diff;

    always_comb
    begin
        rem_sh    = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
    a_done_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg) && $past(cnt_reg) == DIV_CNT_W'(DIV_W - 1))
        else $error("divider finished early");
`endif

endmodule

`default_nettype wire

>>> src/congestion_window_controller_unit.sv
// Top level: congestion window controller with shared multiplier and iterative divider.
// Path from input transfer to result: loss, restart, zero-window ack and slow-start ack
// finish in EXEC, send check in MULT, congestion-avoidance ack in DIV (32-step divider).
// One event at a time; the next input is taken the cycle after a result is registered.
// A finished event waits in its state while the output holds a result not yet accepted.
// Reset (async, active low): segment 1200, window 2400, threshold 65535, no result pending.
`default_nettype none

module congestion_window_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // segment_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [6:0] unacked_packets
    input  wire logic [1:0]  s_tuser,       // [1:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata        // [31:0] window_bytes, [63:32] threshold_bytes,
                                            // [64] send_allowed, [65] in_slow_start
);
    import cwc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MULT = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [15:0]        seg_reg;
    logic [31:0]        window_reg, window_next;
    logic [31:0]        thresh_reg, thresh_next;
    logic [31:0]        mul_reg, mul_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_window_reg, out_window_next;
    logic [31:0]        out_thresh_reg, out_thresh_next;
    logic               out_allow_reg, out_allow_next;
    logic               out_slow_reg, out_slow_next;

    logic [15:0]        mul_b;
    logic [31:0]        mul_p;
    logic [31:0]        min_win;
    logic [31:0]        half_win;
    logic [31:0]        sum_b;
    logic [32:0]        sum;
    logic [31:0]        sat_sum;
    logic               can_load;
    logic               finish;
    logic [31:0]        win_new;
    logic [31:0]        thr_new;
    logic               allow_new;
    logic               div_start;
    div_stat_t          div_stat;
    logic [31:0]        quotient;

    cwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg),
        .divisor  (window_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        mul_b    = (op_reg == OP_SEND) ? 16'(cnt_reg) : seg_reg;
        mul_p    = {16'b0, seg_reg} * {16'b0, mul_b};
        min_win  = {15'b0, seg_reg, 1'b0};
        half_win = {1'b0, window_reg[31:1]};
        sum_b    = (state_reg == S_DIV) ? quotient : {16'b0, seg_reg};
        sum      = {1'b0, window_reg} + {1'b0, sum_b};
        sat_sum  = sum[32] ? '1 : sum[31:0];
        can_load = !out_valid_reg || m_tready;

        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        mul_next        = mul_reg;
        window_next     = window_reg;
        thresh_next     = thresh_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_window_next = out_window_reg;
        out_thresh_next = out_thresh_reg;
        out_allow_next  = out_allow_reg;
        out_slow_next   = out_slow_reg;
        finish          = 1'b0;
        win_new         = window_reg;
        thr_new         = thresh_reg;
        allow_new       = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = op_t'(s_tuser);
                    if ({25'b0, s_tdata[6:0]} > 32'(WINDOW_PACKETS))
                        cnt_next = CNT_W'(WINDOW_PACKETS);
                    else
                        cnt_next = CNT_W'(s_tdata[6:0]);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ACK:
                    begin
                        if (window_reg == '0)
                            finish = 1'b1;
                        else if (window_reg < thresh_reg)
                        begin
                            win_new = sat_sum;
                            finish  = 1'b1;
                        end
                        else
                        begin
                            mul_next   = mul_p;
                            state_next = S_MULT;
                        end
                    end
                    OP_LOSS:
                    begin
                        thr_new = (half_win < min_win) ? min_win : half_win;
                        win_new = min_win;
                        finish  = 1'b1;
                    end
                    OP_SEND:
                    begin
                        mul_next   = mul_p;
                        state_next = S_MULT;
                    end
                    default:
                    begin
                        win_new = min_win;
                        thr_new = RESTART_THRESHOLD;
                        finish  = 1'b1;
                    end
                endcase
            end
            S_MULT:
            begin
                if (op_reg == OP_SEND)
                begin
                    allow_new = mul_reg < window_reg;
                    finish    = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    win_new = sat_sum;
                    finish  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish && can_load)
        begin
            window_next     = win_new;
            thresh_next     = thr_new;
            out_valid_next  = 1'b1;
            out_window_next = win_new;
            out_thresh_next = thr_new;
            out_allow_next  = allow_new;
            out_slow_next   = win_new < thr_new;
            state_next      = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ACK;
            seg_reg       <= SEG_RESET;
            window_reg    <= {15'b0, SEG_RESET, 1'b0};
            thresh_reg    <= RESTART_THRESHOLD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            window_reg    <= window_next;
            thresh_reg    <= thresh_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                seg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        mul_reg        <= mul_next;
        out_window_reg <= out_window_next;
        out_thresh_reg <= out_thresh_next;
        out_allow_reg  <= out_allow_next;
        out_slow_reg   <= out_slow_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_slow_reg, out_allow_reg, out_thresh_reg, out_window_reg};

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an event is in progress");
    a_div_ack_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (op_reg == OP_ACK))
        else $error("divider used for an event other than ack");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> bench/congestion_window_controller_unit_tb.sv
// Self-checking bench for the congestion window controller: directed event cases, then random traffic.
`default_nettype none

module congestion_window_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_SEG  = 78;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic        send_ok;
        logic        slow_start;
    } cwnd_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    logic [15:0] seg_size;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;

    cwnd_result_t cwnd_expected_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int events_sent;
    int results_checked;
    int seg_writes;
    int stall_cycles;

    congestion_window_controller_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic cwnd_result_t apply_event(op_t op, logic [6:0] unacked);
        cwnd_result_t r;
        logic [31:0]  min_win;
        logic [31:0]  growth;
        logic [32:0]  sum;
        logic [6:0]   pkts;
        logic [63:0]  flight_bytes;
        min_win   = {15'd0, seg_size, 1'b0};
        r.send_ok = 1'b0;
        case (op)
            OP_ACK:
            begin
                if (cwnd != 32'd0)
                begin
                    if (cwnd < ssthresh)
                        growth = {16'd0, seg_size};
                    else
                        growth = ({16'd0, seg_size} * {16'd0, seg_size}) / cwnd;
                    sum  = {1'b0, cwnd} + {1'b0, growth};
                    cwnd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            OP_LOSS:
            begin
                ssthresh = cwnd >> 1;
                if (ssthresh < min_win)
                    ssthresh = min_win;
                cwnd = min_win;
            end
            OP_SEND:
            begin
                pkts         = (unacked > WINDOW_PACKETS) ? 7'(WINDOW_PACKETS) : unacked;
                flight_bytes = 64'(pkts) * 64'(seg_size);
                r.send_ok    = (flight_bytes < {32'd0, cwnd});
            end
            default:
            begin
                cwnd     = min_win;
                ssthresh = RESTART_THRESHOLD;
            end
        endcase
        r.window     = cwnd;
        r.threshold  = ssthresh;
        r.slow_start = (cwnd < ssthresh);
        return r;
    endfunction

    task automatic send_event(op_t op, logic [6:0] unacked);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, unacked};
        s_tuser  = op;
        do
            @(posedge clk);
        while (!s_tready);
        cwnd_expected_q.push_back(apply_event(op, unacked));
        events_sent++;
    endtask

    task automatic settle_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (cwnd_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_segment(logic [15:0] value);
        settle_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        seg_size  = value;
        seg_writes++;
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cwnd_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cwnd_expected_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none actual %h", $time, m_tdata);
            end
            else
            begin
                exp_r = cwnd_expected_q.pop_front();
                check_field("window_bytes", exp_r.window, m_tdata[31:0]);
                check_field("threshold_bytes", exp_r.threshold, m_tdata[63:32]);
                check_field("send_allowed", 32'(exp_r.send_ok), 32'(m_tdata[64]));
                check_field("in_slow_start", 32'(exp_r.slow_start), 32'(m_tdata[65]));
                results_checked++;
            end
        end
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, stall_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_reset_values();
        send_event(OP_SEND, 7'd0);
        send_event(OP_SEND, 7'd2);
        send_event(OP_ACK, 7'd127);
    endtask

    // slow start crosses the threshold, then avoidance growth and send checks
    task automatic test_slow_start_to_avoidance();
        write_segment(16'd30000);
        send_event(OP_ACK, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_SEND, 7'd2);
        send_event(OP_SEND, 7'd4);
    endtask

    // window is large against a small segment, so a count over the limit saturates
    task automatic test_unacked_saturation();
        write_segment(16'd1000);
        send_event(OP_SEND, 7'd127);
        send_event(OP_SEND, 7'd65);
        send_event(OP_SEND, 7'd64);
    endtask

    task automatic test_loss_and_restart();
        send_event(OP_LOSS, 7'd0);
        send_event(OP_LOSS, 7'd64);
        send_event(OP_RESTART, 7'd0);
    endtask

    task automatic test_segment_extremes();
        write_segment(16'hFFFF);
        send_event(OP_RESTART, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_SEND, 7'd2);
        write_segment(16'd1);
        send_event(OP_RESTART, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_SEND, 7'd3);
    endtask

    // segment of zero gives a zero window that an ack must leave alone
    task automatic test_zero_window();
        write_segment(16'd0);
        send_event(OP_RESTART, 7'd0);
        send_event(OP_ACK, 7'd0);
        send_event(OP_SEND, 7'd0);
        send_event(OP_LOSS, 7'd0);
        send_event(OP_ACK, 7'd1);
        write_segment(SEG_RESET);
        send_event(OP_RESTART, 7'd0);
    endtask

    task automatic test_random_traffic(logic [15:0] seg_a, logic [15:0] seg_b,
                                       logic [15:0] seg_c);
        logic [15:0] segs [3];
        int          pick;
        int          near;
        op_t         op;
        logic [6:0]  unacked;
        segs[0] = seg_a;
        segs[1] = seg_b;
        segs[2] = seg_c;
        foreach (segs[k])
        begin
            write_segment(segs[k]);
            repeat (ITEMS_PER_SEG)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    op = OP_ACK;
                else if (pick < 80)
                    op = OP_SEND;
                else if (pick < 92)
                    op = OP_LOSS;
                else
                    op = OP_RESTART;
                if (op == OP_SEND && $urandom_range(0, 3) != 0 && seg_size != 16'd0)
                begin
                    near = int'(cwnd / seg_size) + $urandom_range(0, 2) - 1;
                    if (near < 0)
                        near = 0;
                    if (near > 127)
                        near = 127;
                    unacked = 7'(near);
                end
                else if ($urandom_range(0, 3) == 0)
                    unacked = 7'($urandom_range(65, 127));
                else
                    unacked = 7'($urandom_range(0, 64));
                send_event(op, unacked);
            end
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 16'd0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'd0;
        s_tuser         = OP_ACK;
        m_tready        = 1'b0;
        errors          = 0;
        events_sent     = 0;
        results_checked = 0;
        seg_writes      = 0;
        stall_cycles    = 0;
        send_idle_pct   = 33;
        recv_idle_pct   = 87;
        seg_size        = SEG_RESET;
        cwnd            = {15'd0, SEG_RESET, 1'b0};
        ssthresh        = RESTART_THRESHOLD;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_slow_start_to_avoidance();
        test_unacked_saturation();
        test_loss_and_restart();
        test_segment_extremes();
        test_zero_window();

        test_random_traffic(16'd536, 16'hFFFF, 16'd1);
        send_idle_pct = 87;
        recv_idle_pct = 33;
        test_random_traffic(16'd1460, 16'd2, 16'd9000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(16'($urandom_range(1, 65535)), 16'd40000, SEG_RESET);

        settle_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Ran %0d events (ack, loss, send check, restart) over %0d segment writes,",
                 events_sent, seg_writes);
        $display("checked %0d results under three backpressure mixes, %0d errors.",
                 results_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
